// ===== hw/rtl/hthq_pkg.sv =====
// Shared types and codes for the heightmap triangle height query block.
`default_nettype none
package hthq_pkg;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic CFG_GRID_WIDTH = 1'b0;
	localparam logic CFG_GRID_DEPTH = 1'b1;

	localparam int unsigned CFG_W     = 9;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned SAMPLE_W  = 8;
	localparam int unsigned POS_W     = 16;
	localparam int unsigned HEIGHT_W  = 16;

	localparam logic [CFG_W-1:0] GRID_RESET = 9'd256;

	typedef struct packed {
		logic                opcode;
		logic [7:0]          cell_col;
		logic [7:0]          cell_row;
		logic [SAMPLE_W-1:0] sample_value;
		logic [POS_W-1:0]    query_x;
		logic [POS_W-1:0]    query_z;
	} request_t;

	typedef struct packed {
		logic [HEIGHT_W-1:0] terrain_height;
		logic                in_range;
	} result_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] h00;
		logic [SAMPLE_W-1:0] h10;
		logic [SAMPLE_W-1:0] h01;
		logic [SAMPLE_W-1:0] h11;
	} corners_t;

endpackage
`default_nettype wire

// ===== hw/rtl/heightmap_triangle_height_query_top.sv =====
// Top level of the heightmap triangle height query block.
//
// The block takes one request per clock cycle and never raises busy. A write
// request stores one sample and gives no result; it is seen by any query
// accepted from the next cycle on. A query request gives exactly one result,
// strobed by done for a single cycle, after the request has passed the registers
// for the read of the four corner banks, the multiply, and the sum and format.
// The receiver cannot stall: each result must be taken in its cycle. The
// samples sit in four single-port-read banks split by row and column parity,
// so the four corners of any cell are read out together. Stored samples
// are undefined until written.
`default_nettype none
module heightmap_triangle_height_query_top #(
	parameter int MAX_COLS  = 256,
	parameter int MAX_ROWS  = 256,
	parameter int FRAC_BITS = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire hthq_pkg::request_t               request,
	output logic                                  done,
	output hthq_pkg::result_t                     result,
	input  wire logic                             cfg_we,
	input  wire logic [hthq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [hthq_pkg::CFG_W-1:0]       cfg_data
);

	localparam int IW = hthq_pkg::POS_W - FRAC_BITS;
	localparam int CW = IW + 12;

	logic [hthq_pkg::CFG_W-1:0] grid_width_q;
	logic [hthq_pkg::CFG_W-1:0] grid_depth_q;

	logic                 accept;
	logic                 wr_en;
	logic                 rd_en;
	logic [IW-1:0]        ix;
	logic [IW-1:0]        iz;
	logic [CW-1:0]        gw_eff;
	logic [CW-1:0]        gd_eff;
	logic                 in_range;

	logic                 valid_s1;
	logic                 in_range_s1;
	logic [FRAC_BITS-1:0] fx_s1;
	logic [FRAC_BITS-1:0] fz_s1;

	hthq_pkg::corners_t   corners;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign wr_en  = accept && (request.opcode == hthq_pkg::OP_WRITE);
	assign rd_en  = accept && (request.opcode == hthq_pkg::OP_QUERY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= hthq_pkg::GRID_RESET;
			grid_depth_q <= hthq_pkg::GRID_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hthq_pkg::CFG_GRID_WIDTH: begin
					grid_width_q <= cfg_data;
				end
				hthq_pkg::CFG_GRID_DEPTH: begin
					grid_depth_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		ix     = request.query_x[hthq_pkg::POS_W-1:FRAC_BITS];
		iz     = request.query_z[hthq_pkg::POS_W-1:FRAC_BITS];
		gw_eff = (CW'(grid_width_q) > CW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(grid_width_q);
		gd_eff = (CW'(grid_depth_q) > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(grid_depth_q);
		in_range = ((CW'(ix) + CW'(1)) < gw_eff) && ((CW'(iz) + CW'(1)) < gd_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			in_range_s1 <= in_range;
			fx_s1       <= request.query_x[FRAC_BITS-1:0];
			fz_s1       <= request.query_z[FRAC_BITS-1:0];
		end
	end

	hthq_bank_store #(
		.MAX_COLS  (MAX_COLS),
		.MAX_ROWS  (MAX_ROWS),
		.FRAC_BITS (FRAC_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_col  (request.cell_col),
		.wr_row  (request.cell_row),
		.wr_data (request.sample_value),
		.rd_en   (rd_en),
		.rd_x    (ix),
		.rd_z    (iz),
		.corners (corners)
	);

	hthq_interp #(
		.FRAC_BITS (FRAC_BITS)
	) u_interp (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.in_range_s1 (in_range_s1),
		.fx_s1       (fx_s1),
		.fz_s1       (fz_s1),
		.corners     (corners),
		.done        (done),
		.result      (result)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/hthq_bank_store.sv =====
// Height sample store split into four parity banks, one corner read per bank per cycle.
`default_nettype none
module hthq_bank_store #(
	parameter int MAX_COLS  = 256,
	parameter int MAX_ROWS  = 256,
	parameter int FRAC_BITS = 8
) (
	input  wire logic                                clk,
	input  wire logic                                wr_en,
	input  wire logic [7:0]                          wr_col,
	input  wire logic [7:0]                          wr_row,
	input  wire logic [hthq_pkg::SAMPLE_W-1:0]       wr_data,
	input  wire logic                                rd_en,
	input  wire logic [hthq_pkg::POS_W-FRAC_BITS-1:0] rd_x,
	input  wire logic [hthq_pkg::POS_W-FRAC_BITS-1:0] rd_z,
	output hthq_pkg::corners_t                       corners
);

	localparam int IW       = hthq_pkg::POS_W - FRAC_BITS;
	localparam int HALF_C   = (MAX_COLS + 1) / 2;
	localparam int HALF_R   = (MAX_ROWS + 1) / 2;
	localparam int CHW      = (HALF_C > 1) ? $clog2(HALF_C) : 1;
	localparam int RHW      = (HALF_R > 1) ? $clog2(HALF_R) : 1;
	localparam int AW       = CHW + RHW;
	localparam int DEPTH    = 2 ** AW;
	localparam int XW       = IW + 12;

	logic          wr_ok;
	logic [1:0]    wr_bank;
	logic [AW-1:0] wr_addr;
	logic [XW-1:0] wr_col_h;
	logic [XW-1:0] wr_row_h;
	logic [XW-1:0] col_even_h;
	logic [XW-1:0] col_odd_h;
	logic [XW-1:0] row_even_h;
	logic [XW-1:0] row_odd_h;
	logic [AW-1:0] rd_addr [4];
	logic [hthq_pkg::SAMPLE_W-1:0] rd_data_s1 [4];
	logic          px_s1;
	logic          pz_s1;

	always_comb begin
		wr_ok    = (XW'(wr_col) < XW'(MAX_COLS)) && (XW'(wr_row) < XW'(MAX_ROWS));
		wr_bank  = {wr_row[0], wr_col[0]};
		wr_col_h = XW'(wr_col[7:1]);
		wr_row_h = XW'(wr_row[7:1]);
		wr_addr  = {wr_row_h[RHW-1:0], wr_col_h[CHW-1:0]};

		col_even_h = (XW'(rd_x) + XW'(1)) >> 1;
		col_odd_h  = XW'(rd_x) >> 1;
		row_even_h = (XW'(rd_z) + XW'(1)) >> 1;
		row_odd_h  = XW'(rd_z) >> 1;

		rd_addr[0] = {row_even_h[RHW-1:0], col_even_h[CHW-1:0]};
		rd_addr[1] = {row_even_h[RHW-1:0], col_odd_h[CHW-1:0]};
		rd_addr[2] = {row_odd_h[RHW-1:0],  col_even_h[CHW-1:0]};
		rd_addr[3] = {row_odd_h[RHW-1:0],  col_odd_h[CHW-1:0]};
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [hthq_pkg::SAMPLE_W-1:0] mem [DEPTH];

		always_ff @(posedge clk) begin
			if (wr_en && wr_ok && (wr_bank == 2'(b))) begin
				mem[wr_addr] <= wr_data;
			end
			if (rd_en) begin
				rd_data_s1[b] <= mem[rd_addr[b]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			px_s1 <= rd_x[0];
			pz_s1 <= rd_z[0];
		end
	end

	// route banks back to corners by the parity of the cell origin
	always_comb begin
		corners.h00 = rd_data_s1[{pz_s1,  px_s1}];
		corners.h10 = rd_data_s1[{pz_s1,  ~px_s1}];
		corners.h01 = rd_data_s1[{~pz_s1, px_s1}];
		corners.h11 = rd_data_s1[{~pz_s1, ~px_s1}];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/hthq_interp.sv =====
// Triangle selection, plane interpolation and output formatting pipeline.
`default_nettype none
module hthq_interp #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 valid_s1,
	input  wire logic                 in_range_s1,
	input  wire logic [FRAC_BITS-1:0] fx_s1,
	input  wire logic [FRAC_BITS-1:0] fz_s1,
	input  wire hthq_pkg::corners_t   corners,
	output logic                      done,
	output hthq_pkg::result_t         result
);

	localparam int F   = FRAC_BITS;
	localparam int WW  = F + 1;
	localparam int PW  = F + 11;
	localparam int SW  = F + 12;
	localparam int UW  = SW + 8;

	logic                  upper;
	logic [WW-1:0]         fsum;
	logic [WW-1:0]         w1;
	logic [WW-1:0]         w2;
	logic signed [8:0]     d1;
	logic signed [8:0]     d2;
	logic [7:0]            base;
	logic signed [PW-1:0]  prod_a;
	logic signed [PW-1:0]  prod_b;

	logic                  valid_s2;
	logic                  in_range_s2;
	logic [7:0]            base_s2;
	logic signed [PW-1:0]  prod_a_s2;
	logic signed [PW-1:0]  prod_b_s2;

	logic signed [SW-1:0]  sum;
	logic [UW-1:0]         mag;
	logic [UW-1:0]         scaled;
	logic [15:0]           height;

	logic                  done_q;
	hthq_pkg::result_t     result_q;

	always_comb begin
		fsum  = WW'(fx_s1) + WW'(fz_s1);
		upper = fsum[F];
		if (!upper) begin
			base = corners.h00;
			d1   = $signed({1'b0, corners.h10}) - $signed({1'b0, corners.h00});
			d2   = $signed({1'b0, corners.h01}) - $signed({1'b0, corners.h00});
			w1   = WW'(fx_s1);
			w2   = WW'(fz_s1);
		end else begin
			base = corners.h11;
			d1   = $signed({1'b0, corners.h01}) - $signed({1'b0, corners.h11});
			d2   = $signed({1'b0, corners.h10}) - $signed({1'b0, corners.h11});
			w1   = (WW'(1) << F) - WW'(fx_s1);
			w2   = (WW'(1) << F) - WW'(fz_s1);
		end
		prod_a = PW'($signed({1'b0, w1})) * PW'(d1);
		prod_b = PW'($signed({1'b0, w2})) * PW'(d2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		in_range_s2 <= in_range_s1;
		base_s2     <= base;
		prod_a_s2   <= prod_a;
		prod_b_s2   <= prod_b;
	end

	always_comb begin
		sum = $signed(SW'({base_s2, F'(0)})) + SW'(prod_a_s2) + SW'(prod_b_s2);
		mag = sum[SW-1] ? '0 : UW'($unsigned(sum));
	end

	if (F > 8) begin : g_round
		assign scaled = (mag + (UW'(1) << (F - 9))) >> (F - 8);
	end else if (F < 8) begin : g_widen
		assign scaled = mag << (8 - F);
	end else begin : g_direct
		assign scaled = mag;
	end

	assign height = (|scaled[UW-1:16]) ? 16'hFFFF : scaled[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		result_q.terrain_height <= in_range_s2 ? height : '0;
		result_q.in_range       <= in_range_s2;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

// ===== sim/tb_heightmap_triangle_height_query_top.sv =====
// Self-checking testbench for the heightmap triangle height query block.
`timescale 1ns / 1ps
module tb_heightmap_triangle_height_query_top;
	import hthq_pkg::*;

	localparam int MAX_COLS     = 256;
	localparam int MAX_ROWS     = 256;
	localparam int FRAC_BITS    = 8;
	localparam int STORE_DEPTH  = MAX_COLS * MAX_ROWS;
	localparam longint FRAC_ONE = longint'(1) << FRAC_BITS;
	localparam int FRAC_MASK    = (1 << FRAC_BITS) - 1;
	localparam int ROUND_SH     = (FRAC_BITS > 8) ? FRAC_BITS - 8 : 0;
	localparam int LEFT_SH      = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
	localparam int DRAIN_CYCLES = 4;
	localparam int STALL_LIMIT  = 1000;
	localparam int RANDOM_ITEMS = 1600;
	localparam int NUM_PHASES   = 8;

	class terrain_scoreboard;
		bit [SAMPLE_W-1:0] samples [STORE_DEPTH];
		int unsigned       grid_w = GRID_RESET;
		int unsigned       grid_d = GRID_RESET;
		result_t           expected_heights [$];
		int unsigned       fails = 0;

		function longint sample_at(int unsigned c, int unsigned r);
			if (c >= MAX_COLS || r >= MAX_ROWS)
				return 0;
			return longint'(samples[r * MAX_COLS + c]);
		endfunction

		function result_t predict_height(request_t q);
			int unsigned gw, gd, ix, iz;
			longint      fx, fz, h00, h10, h01, h11, v;
			result_t     res;
			res = '0;
			gw = (grid_w > MAX_COLS) ? MAX_COLS : grid_w;
			gd = (grid_d > MAX_ROWS) ? MAX_ROWS : grid_d;
			ix = int'(q.query_x) >> FRAC_BITS;
			iz = int'(q.query_z) >> FRAC_BITS;
			if (ix + 1 >= gw || iz + 1 >= gd)
				return res;
			fx  = longint'(int'(q.query_x) & FRAC_MASK);
			fz  = longint'(int'(q.query_z) & FRAC_MASK);
			h00 = sample_at(ix, iz);
			h10 = sample_at(ix + 1, iz);
			h01 = sample_at(ix, iz + 1);
			h11 = sample_at(ix + 1, iz + 1);
			if (fx + fz < FRAC_ONE)
				v = h00 * FRAC_ONE + fx * (h10 - h00) + fz * (h01 - h00);
			else
				v = h11 * FRAC_ONE + (FRAC_ONE - fx) * (h01 - h11) + (FRAC_ONE - fz) * (h10 - h11);
			if (v < 0)
				v = 0;
			v = (v + ((longint'(1) << ROUND_SH) >>> 1)) >>> ROUND_SH;
			v = v <<< LEFT_SH;
			if (v > 65535)
				v = 65535;
			res.terrain_height = v[HEIGHT_W-1:0];
			res.in_range       = 1'b1;
			return res;
		endfunction

		function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == CFG_GRID_WIDTH)
				grid_w = val;
			else
				grid_d = val;
		endfunction

		function void note_request(request_t q);
			if (q.opcode == OP_WRITE) begin
				if (q.cell_col < MAX_COLS && q.cell_row < MAX_ROWS)
					samples[q.cell_row * MAX_COLS + q.cell_col] = q.sample_value;
			end else begin
				expected_heights.push_back(predict_height(q));
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_heights.size() == 0) begin
				fails++;
				$error("result strobe with no query pending: terrain_height %0d in_range %0d",
					got.terrain_height, got.in_range);
				return;
			end
			want = expected_heights.pop_front();
			if (got.terrain_height !== want.terrain_height) begin
				fails++;
				$error("terrain_height: expected %0d, actual %0d",
					want.terrain_height, got.terrain_height);
			end
			if (got.in_range !== want.in_range) begin
				fails++;
				$error("in_range: expected %0d, actual %0d", want.in_range, got.in_range);
			end
		endfunction

		function int pending();
			return expected_heights.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 busy;
	request_t             request   = '0;
	logic                 done;
	result_t              result;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_GRID_WIDTH;
	logic [CFG_W-1:0]     cfg_data  = '0;

	terrain_scoreboard sb = new();

	bit written [STORE_DEPTH];
	bit cell_ready [STORE_DEPTH];
	int ready_cells [$];
	int cur_w       = GRID_RESET;
	int cur_d       = GRID_RESET;
	int items_sent  = 0;
	bit no_gap      = 1'b0;
	int stall_cycles = 0;

	heightmap_triangle_height_query_top #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS),
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	function automatic int eff_dim(int v, int maxv);
		return (v > maxv) ? maxv : v;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic request_t random_request(logic op);
		request_t req;
		req.opcode       = op;
		req.cell_col     = 8'($urandom);
		req.cell_row     = 8'($urandom);
		req.sample_value = 8'($urandom);
		req.query_x      = 16'($urandom);
		req.query_z      = 16'($urandom);
		return req;
	endfunction

	// Fraction pair {fx, fz}: corners, the triangle tie and just below it, or random.
	function automatic logic [15:0] pick_frac();
		int fx, fz;
		case ($urandom_range(0, 9))
			0: begin fx = 0; fz = 0; end
			1: begin fx = 255; fz = 255; end
			2: begin fx = $urandom_range(1, 255); fz = 256 - fx; end
			3: begin fx = $urandom_range(0, 255); fz = 255 - fx; end
			default: begin fx = $urandom_range(0, 255); fz = $urandom_range(0, 255); end
		endcase
		return {fx[7:0], fz[7:0]};
	endfunction

	task automatic mark_written(int c, int r);
		int cc, rr, base;
		written[r * MAX_COLS + c] = 1'b1;
		for (int dr = 0; dr < 2; dr++) begin
			for (int dc = 0; dc < 2; dc++) begin
				cc = c - dc;
				rr = r - dr;
				if (cc >= 0 && rr >= 0 && cc < MAX_COLS - 1 && rr < MAX_ROWS - 1) begin
					base = rr * MAX_COLS + cc;
					if (!cell_ready[base] && written[base] && written[base + 1]
							&& written[base + MAX_COLS] && written[base + MAX_COLS + 1]) begin
						cell_ready[base] = 1'b1;
						ready_cells.push_back(base);
					end
				end
			end
		end
	endtask

	task automatic send_request(request_t req);
		int n;
		start   <= 1'b1;
		request <= req;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(req);
		items_sent++;
		if (items_sent % 64 == 0)
			no_gap = ($urandom_range(0, 3) == 0);
		if (!no_gap) begin
			n = gap_len();
			if (n > 0) begin
				start <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	endtask

	task automatic quiesce();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int val);
		quiesce();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_config(idx, val[CFG_W-1:0]);
		if (idx == CFG_GRID_WIDTH)
			cur_w = val;
		else
			cur_d = val;
	endtask

	task automatic issue_write(int c, int r, int v);
		request_t req;
		req              = random_request(OP_WRITE);
		req.cell_col     = c[7:0];
		req.cell_row     = r[7:0];
		req.sample_value = v[7:0];
		mark_written(c, r);
		send_request(req);
	endtask

	task automatic issue_query(logic [15:0] x, logic [15:0] z);
		request_t req;
		req         = random_request(OP_QUERY);
		req.query_x = x;
		req.query_z = z;
		send_request(req);
	endtask

	task automatic query_outside();
		int gw, gd, ix, iz;
		gw = eff_dim(cur_w, MAX_COLS);
		gd = eff_dim(cur_d, MAX_ROWS);
		if ($urandom_range(0, 1)) begin
			ix = $urandom_range((gw > 0) ? gw - 1 : 0, 255);
			iz = $urandom_range(0, 255);
		end else begin
			ix = $urandom_range(0, 255);
			iz = $urandom_range((gd > 0) ? gd - 1 : 0, 255);
		end
		issue_query({ix[7:0], 8'($urandom)}, {iz[7:0], 8'($urandom)});
	endtask

	task automatic query_ready_cell();
		int gw, gd, base, c, r;
		logic [15:0] f;
		gw = eff_dim(cur_w, MAX_COLS);
		gd = eff_dim(cur_d, MAX_ROWS);
		if (ready_cells.size() != 0) begin
			for (int t = 0; t < 8; t++) begin
				base = ready_cells[$urandom_range(0, ready_cells.size() - 1)];
				c = base % MAX_COLS;
				r = base / MAX_COLS;
				if (c + 1 < gw && r + 1 < gd) begin
					f = pick_frac();
					issue_query({c[7:0], f[15:8]}, {r[7:0], f[7:0]});
					return;
				end
			end
		end
		query_outside();
	endtask

	task automatic run_cell_sequence();
		int gw, gd, c, r, k, rot, v, nq;
		logic [15:0] f;
		gw = eff_dim(cur_w, MAX_COLS);
		gd = eff_dim(cur_d, MAX_ROWS);
		c = (gw >= 2) ? $urandom_range(0, gw - 2) : $urandom_range(0, MAX_COLS - 2);
		r = (gd >= 2) ? $urandom_range(0, gd - 2) : $urandom_range(0, MAX_ROWS - 2);
		rot = $urandom_range(0, 3);
		for (int i = 0; i < 4; i++) begin
			k = (rot + i) % 4;
			if ($urandom_range(0, 4) == 0)
				v = $urandom_range(0, 1) ? 255 : 0;
			else
				v = $urandom_range(0, 255);
			issue_write(c + (k % 2), r + (k / 2), v);
		end
		nq = $urandom_range(1, 3);
		for (int i = 0; i < nq; i++) begin
			f = pick_frac();
			issue_query({c[7:0], f[15:8]}, {r[7:0], f[7:0]});
		end
	endtask

	initial begin
		int phase_w [NUM_PHASES];
		int phase_d [NUM_PHASES];
		int phase_end, r;

		phase_w = '{2, 511, 0, 3, 256, 17, 0, 0};
		phase_d = '{2, 511, 1, 257, 2, 5, 0, 0};
		phase_w[6] = $urandom_range(2, 40);
		phase_d[6] = $urandom_range(2, 40);
		phase_w[7] = $urandom_range(0, 511);
		phase_d[7] = $urandom_range(0, 511);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue_write(0, 0, 0);
		issue_write(1, 0, 255);
		issue_write(0, 1, 255);
		issue_write(1, 1, 0);
		issue_query(16'h0000, 16'h0000);
		issue_query(16'h0080, 16'h0080);
		issue_query(16'h007F, 16'h0080);
		issue_query(16'h00FF, 16'h00FF);
		issue_write(254, 254, 255);
		issue_write(255, 254, 0);
		issue_write(254, 255, 128);
		issue_write(255, 255, 255);
		issue_query(16'hFEFF, 16'hFEFF);
		issue_query(16'hFE00, 16'hFE00);
		issue_query(16'hFE01, 16'hFEFF);
		issue_query(16'hFF00, 16'h0000);
		issue_query(16'h0000, 16'hFF00);
		issue_query(16'hFFFF, 16'hFFFF);

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_cfg(CFG_GRID_WIDTH, phase_w[p]);
			write_cfg(CFG_GRID_DEPTH, phase_d[p]);
			phase_end = items_sent + RANDOM_ITEMS / NUM_PHASES;
			while (items_sent < phase_end) begin
				r = $urandom_range(0, 99);
				if (r < 50)
					run_cell_sequence();
				else if (r < 75)
					query_ready_cell();
				else if (r < 87)
					query_outside();
				else
					issue_write($urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255));
				if ($urandom_range(0, 99) == 0)
					quiesce();
			end
		end

		quiesce();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
